### design/rsz_pkg.sv
// Shared constants and types for the bilinear image resampler.
package rsz_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_CHANNELS = 4;

    localparam int COL_W   = 8;
    localparam int ROW_W   = 8;
    localparam int CH_W    = 2;
    localparam int SMP_W   = 8;
    localparam int SIZE_W  = 9;
    localparam int NCH_W   = 3;
    localparam int SCALE_W = 25;
    localparam int FRAC_W  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam int BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2) * MAX_CHANNELS;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    localparam int T_W   = COL_W + 1 + SCALE_W;
    localparam int POS_W = COL_W + FRAC_W;
    localparam int WT_W  = FRAC_W + 1;
    localparam int H_W   = SMP_W + FRAC_W;
    localparam int M_W   = H_W + WT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_CHANNELS   = 3'd4,
        REG_X_SCALE    = 3'd5,
        REG_Y_SCALE    = 3'd6
    } cfg_reg_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

endpackage

### design/rsz_ifs.sv
// Handshake channel interfaces for the resampler requests, results and configuration.
interface rsz_req_if;
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [rsz_pkg::COL_W-1:0] column;
    logic [rsz_pkg::ROW_W-1:0] row;
    logic [rsz_pkg::CH_W-1:0]  channel;
    logic [rsz_pkg::SMP_W-1:0] sample;
    modport source (output valid, command, column, row, channel, sample, input ready);
    modport sink (input valid, command, column, row, channel, sample, output ready);
endinterface

interface rsz_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [rsz_pkg::SMP_W-1:0] out_sample;
    logic                     in_range;
    modport source (output valid, out_sample, in_range, input ready);
    modport sink (input valid, out_sample, in_range, output ready);
endinterface

interface rsz_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rsz_pkg::CFG_IDX_W-1:0]  index;
    logic [rsz_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### design/rsz_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module rsz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/bilinear_image_resampler_unit.sv
// Top level of the bilinear image resampler with half-pixel centers.
// The req channel carries command beats. A write beat (command 0) stores one
// 8-bit sample at its column, row and channel and gives no result. A read beat
// (command 1) names a destination column, row and channel and gives exactly one
// beat on the rsp channel, with out_sample and in_range.
// The cfg channel writes the size, channel count and scale registers by index;
// it is always ready and must only be used while no read is in flight.
// The block is a six-stage pipeline and takes one beat per cycle while rsp
// does not stall. The source store is split into four banks by column and
// row parity, so the four neighbors of a sample are read in the same cycle,
// at the same stage that writes, which keeps writes and reads in order.
// When rsp stalls, the whole pipeline holds and req.ready falls; nothing is
// lost or repeated. Reset clears the valid bits and sets the registers to
// their defaults; the store contents are undefined until written.
module bilinear_image_resampler_unit (
    input logic       clk,
    input logic       rst_n,
    rsz_req_if.sink   req,
    rsz_rsp_if.source rsp,
    rsz_cfg_if.sink   cfg
);

    logic [rsz_pkg::SIZE_W-1:0]  src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic [rsz_pkg::NCH_W-1:0]   channels_reg;
    logic [rsz_pkg::SCALE_W-1:0] x_scale_reg, y_scale_reg;

    logic adv;

    logic                      v1_reg, cmd1_reg;
    logic [rsz_pkg::COL_W-1:0] col1_reg;
    logic [rsz_pkg::ROW_W-1:0] row1_reg;
    logic [rsz_pkg::CH_W-1:0]  ch1_reg;
    logic [rsz_pkg::SMP_W-1:0] smp1_reg;

    logic                      v2_reg, cmd2_reg, ok2_reg, id2_reg;
    logic [rsz_pkg::T_W-1:0]   tx2_reg, ty2_reg;
    logic [rsz_pkg::COL_W-1:0] col2_reg;
    logic [rsz_pkg::ROW_W-1:0] row2_reg;
    logic [rsz_pkg::CH_W-1:0]  ch2_reg;
    logic [rsz_pkg::SMP_W-1:0] smp2_reg;

    logic                       v3_reg, cmd3_reg, ok3_reg;
    logic                       x0p3_reg, x1p3_reg, y0p3_reg, y1p3_reg;
    logic [rsz_pkg::FRAC_W-1:0] a3_reg, c3_reg;

    logic                       v4_reg, cmd4_reg, ok4_reg;
    logic [rsz_pkg::H_W-1:0]    h0_4_reg, h1_4_reg;
    logic [rsz_pkg::FRAC_W-1:0] c4_reg;

    logic                    v5_reg, cmd5_reg, ok5_reg;
    logic [rsz_pkg::M_W-1:0] m0_5_reg, m1_5_reg;

    logic                      out_valid_reg, in_range_reg;
    logic [rsz_pkg::SMP_W-1:0] out_sample_reg;

    logic [rsz_pkg::SIZE_W-1:0] sw, sh;
    logic [rsz_pkg::POS_W-1:0]  px, py;
    logic [rsz_pkg::COL_W-1:0]  x0, x1;
    logic [rsz_pkg::ROW_W-1:0]  y0, y1;
    logic [rsz_pkg::FRAC_W-1:0] a2, c2;

    logic                        bank_we    [4];
    logic [rsz_pkg::BANK_AW-1:0] bank_raddr [4];
    logic [rsz_pkg::BANK_AW-1:0] waddr;
    logic [rsz_pkg::SMP_W-1:0]   bank_rdata [4];

    function automatic logic [rsz_pkg::SIZE_W-1:0] clamp_size(
        input logic [rsz_pkg::SIZE_W-1:0] v,
        input logic [rsz_pkg::SIZE_W-1:0] maxv
    );
        if (v == '0)
        begin
            return rsz_pkg::SIZE_W'(1);
        end
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic logic [rsz_pkg::POS_W-1:0] position(
        input logic [rsz_pkg::T_W-1:0]    t,
        input logic [rsz_pkg::SIZE_W-1:0] size
    );
        logic [rsz_pkg::T_W-1:0]   tm;
        logic [rsz_pkg::T_W-2:0]   p;
        logic [rsz_pkg::POS_W-1:0] lim;
        tm  = t - (rsz_pkg::T_W'(1) << rsz_pkg::FRAC_W);
        p   = (t <= (rsz_pkg::T_W'(1) << rsz_pkg::FRAC_W)) ? '0 : tm[rsz_pkg::T_W-1:1];
        lim = {rsz_pkg::COL_W'(size - rsz_pkg::SIZE_W'(1)), rsz_pkg::FRAC_W'(0)};
        return (p > (rsz_pkg::T_W-1)'(lim)) ? lim : p[rsz_pkg::POS_W-1:0];
    endfunction

    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv;
    assign cfg.ready = 1'b1;

    assign rsp.valid      = out_valid_reg;
    assign rsp.out_sample = out_sample_reg;
    assign rsp.in_range   = in_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= rsz_pkg::SIZE_W'(256);
            src_height_reg <= rsz_pkg::SIZE_W'(256);
            dst_width_reg  <= rsz_pkg::SIZE_W'(256);
            dst_height_reg <= rsz_pkg::SIZE_W'(256);
            channels_reg   <= rsz_pkg::NCH_W'(3);
            x_scale_reg    <= rsz_pkg::SCALE_W'(65536);
            y_scale_reg    <= rsz_pkg::SCALE_W'(65536);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                rsz_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg.data[rsz_pkg::SIZE_W-1:0];
                rsz_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg.data[rsz_pkg::SIZE_W-1:0];
                rsz_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg.data[rsz_pkg::SIZE_W-1:0];
                rsz_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg.data[rsz_pkg::SIZE_W-1:0];
                rsz_pkg::REG_CHANNELS:   channels_reg   <= cfg.data[rsz_pkg::NCH_W-1:0];
                rsz_pkg::REG_X_SCALE:    x_scale_reg    <= cfg.data[rsz_pkg::SCALE_W-1:0];
                rsz_pkg::REG_Y_SCALE:    y_scale_reg    <= cfg.data[rsz_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        sw = clamp_size(src_width_reg, rsz_pkg::SIZE_W'(rsz_pkg::MAX_WIDTH));
        sh = clamp_size(src_height_reg, rsz_pkg::SIZE_W'(rsz_pkg::MAX_HEIGHT));
        px = position(tx2_reg, sw);
        py = position(ty2_reg, sh);
        if (id2_reg)
        begin
            x0 = col2_reg;
            x1 = col2_reg;
            y0 = row2_reg;
            y1 = row2_reg;
            a2 = '0;
            c2 = '0;
        end
        else
        begin
            x0 = px[rsz_pkg::POS_W-1:rsz_pkg::FRAC_W];
            y0 = py[rsz_pkg::POS_W-1:rsz_pkg::FRAC_W];
            a2 = px[rsz_pkg::FRAC_W-1:0];
            c2 = py[rsz_pkg::FRAC_W-1:0];
            x1 = ((rsz_pkg::SIZE_W'(x0) + rsz_pkg::SIZE_W'(1)) < sw) ?
                 x0 + rsz_pkg::COL_W'(1) : rsz_pkg::COL_W'(sw - rsz_pkg::SIZE_W'(1));
            y1 = ((rsz_pkg::SIZE_W'(y0) + rsz_pkg::SIZE_W'(1)) < sh) ?
                 y0 + rsz_pkg::ROW_W'(1) : rsz_pkg::ROW_W'(sh - rsz_pkg::SIZE_W'(1));
        end
        waddr = {row2_reg[rsz_pkg::ROW_W-1:1], col2_reg[rsz_pkg::COL_W-1:1], ch2_reg};
        for (int i = 0; i < 4; i++)
        begin
            logic [1:0]                bi;
            logic [rsz_pkg::COL_W-1:0] rx;
            logic [rsz_pkg::ROW_W-1:0] ry;
            bi = 2'(i);
            rx = (x0[0] == bi[0]) ? x0 : x1;
            ry = (y0[0] == bi[1]) ? y0 : y1;
            bank_raddr[i] = {ry[rsz_pkg::ROW_W-1:1], rx[rsz_pkg::COL_W-1:1], ch2_reg};
            bank_we[i]    = adv && v2_reg && (cmd2_reg == rsz_pkg::CMD_WRITE) &&
                            (col2_reg[0] == bi[0]) && (row2_reg[0] == bi[1]);
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        rsz_ram #(
            .WIDTH (rsz_pkg::SMP_W),
            .DEPTH (rsz_pkg::BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[g]),
            .waddr (waddr),
            .wdata (smp2_reg),
            .re    (adv),
            .raddr (bank_raddr[g]),
            .rdata (bank_rdata[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= req.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg && (cmd5_reg == rsz_pkg::CMD_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg <= req.command;
            col1_reg <= req.column;
            row1_reg <= req.row;
            ch1_reg  <= req.channel;
            smp1_reg <= req.sample;

            cmd2_reg <= cmd1_reg;
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
            ch2_reg  <= ch1_reg;
            smp2_reg <= smp1_reg;
            ok2_reg  <= (rsz_pkg::SIZE_W'(col1_reg) < dst_width_reg) &&
                        (rsz_pkg::SIZE_W'(row1_reg) < dst_height_reg) &&
                        (rsz_pkg::NCH_W'(ch1_reg) < channels_reg);
            id2_reg  <= (src_width_reg == dst_width_reg) && (src_height_reg == dst_height_reg);
            tx2_reg  <= rsz_pkg::T_W'({col1_reg, 1'b1}) * rsz_pkg::T_W'(x_scale_reg);
            ty2_reg  <= rsz_pkg::T_W'({row1_reg, 1'b1}) * rsz_pkg::T_W'(y_scale_reg);

            cmd3_reg <= cmd2_reg;
            ok3_reg  <= ok2_reg;
            x0p3_reg <= x0[0];
            x1p3_reg <= x1[0];
            y0p3_reg <= y0[0];
            y1p3_reg <= y1[0];
            a3_reg   <= a2;
            c3_reg   <= c2;

            cmd4_reg <= cmd3_reg;
            ok4_reg  <= ok3_reg;
            c4_reg   <= c3_reg;
            h0_4_reg <= rsz_pkg::H_W'(
                rsz_pkg::M_W'(bank_rdata[{y0p3_reg, x0p3_reg}]) *
                    rsz_pkg::M_W'((rsz_pkg::WT_W'(1) << rsz_pkg::FRAC_W) - rsz_pkg::WT_W'(a3_reg)) +
                rsz_pkg::M_W'(bank_rdata[{y0p3_reg, x1p3_reg}]) * rsz_pkg::M_W'(a3_reg));
            h1_4_reg <= rsz_pkg::H_W'(
                rsz_pkg::M_W'(bank_rdata[{y1p3_reg, x0p3_reg}]) *
                    rsz_pkg::M_W'((rsz_pkg::WT_W'(1) << rsz_pkg::FRAC_W) - rsz_pkg::WT_W'(a3_reg)) +
                rsz_pkg::M_W'(bank_rdata[{y1p3_reg, x1p3_reg}]) * rsz_pkg::M_W'(a3_reg));

            cmd5_reg <= cmd4_reg;
            ok5_reg  <= ok4_reg;
            m0_5_reg <= rsz_pkg::M_W'(h0_4_reg) *
                        rsz_pkg::M_W'((rsz_pkg::WT_W'(1) << rsz_pkg::FRAC_W) - rsz_pkg::WT_W'(c4_reg));
            m1_5_reg <= rsz_pkg::M_W'(h1_4_reg) * rsz_pkg::M_W'(c4_reg);

            in_range_reg   <= ok5_reg;
            out_sample_reg <= ok5_reg ? (rsz_pkg::SMP_W)'((m0_5_reg + m1_5_reg +
                              (rsz_pkg::M_W'(1) << (2 * rsz_pkg::FRAC_W - 1))) >>
                              (2 * rsz_pkg::FRAC_W)) : '0;
        end
    end

endmodule
